// ===== design/staw_pkg.sv =====
// ----------------------------------------------------------------------------
// staw_pkg
// shared types and constants of the strided tensor address walker
// ----------------------------------------------------------------------------
package staw_pkg;

    // field widths
    localparam int DIMS_W       = 2;
    localparam int EXTENT_W     = 16;
    localparam int STRIDE_W     = 24;
    localparam int INDEX_W      = 16;
    localparam int POS_W        = 32;
    localparam int PROD_W       = INDEX_W + STRIDE_W;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 24;

    // parameter defaults
    localparam int DEFAULT_MAX_DIMS  = 3;
    localparam int DEFAULT_ADDR_BITS = 32;

    // item kinds
    typedef enum logic [1:0] {
        KIND_WALK    = 2'd0,
        KIND_RESTART = 2'd1,
        KIND_LOOKUP  = 2'd2
    } kind_t;

    // register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DIMS_IN_USE   = 3'd0,
        CFG_EXTENT_FIRST  = 3'd1,
        CFG_EXTENT_SECOND = 3'd2,
        CFG_EXTENT_THIRD  = 3'd3,
        CFG_STRIDE_FIRST  = 3'd4,
        CFG_STRIDE_SECOND = 3'd5,
        CFG_STRIDE_THIRD  = 3'd6,
        CFG_BASE_OFFSET   = 3'd7
    } cfg_reg_t;

    // control from the top level to the walk state
    typedef struct packed {
        logic step;     // a walk or restart item is accepted
        logic restart;  // that item rewinds first
        logic rewind;   // configuration write
    } walk_ctrl_t;

endpackage

// ===== design/staw_walker.sv =====
// ----------------------------------------------------------------------------
// staw_walker
// walk state: per-dimension counters and address offsets, carry logic
// ----------------------------------------------------------------------------
module staw_walker #(
    parameter int MAX_DIMS  = staw_pkg::DEFAULT_MAX_DIMS,
    parameter int ADDR_BITS = staw_pkg::DEFAULT_ADDR_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  staw_pkg::walk_ctrl_t              ctrl,
    input  logic [MAX_DIMS-1:0]               used,
    input  logic [staw_pkg::EXTENT_W-1:0]     extent [MAX_DIMS],
    input  logic [staw_pkg::STRIDE_W-1:0]     stride [MAX_DIMS],
    output logic [ADDR_BITS-1:0]              cur_offset [MAX_DIMS],
    output logic [staw_pkg::POS_W-1:0]        cur_pos,
    output logic                              cur_last
);

    logic [staw_pkg::EXTENT_W-1:0] cnt_reg  [MAX_DIMS];
    logic [staw_pkg::EXTENT_W-1:0] cnt_next [MAX_DIMS];
    logic [staw_pkg::EXTENT_W-1:0] cnt_cur  [MAX_DIMS];
    logic [ADDR_BITS-1:0]          off_reg  [MAX_DIMS];
    logic [ADDR_BITS-1:0]          off_next [MAX_DIMS];
    logic [staw_pkg::POS_W-1:0]    pos_reg;
    logic [staw_pkg::POS_W-1:0]    pos_next;
    logic [MAX_DIMS:0]             used_ext;
    logic [MAX_DIMS:0]             last_ext;
    logic [MAX_DIMS:0]             carry;

    // current element, rewound for a restart item
    always_comb
    begin
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            cnt_cur[d]    = ctrl.restart ? '0 : cnt_reg[d];
            cur_offset[d] = ctrl.restart ? '0 : off_reg[d];
        end
        cur_pos = ctrl.restart ? '0 : pos_reg;
    end

    // per-dimension last position and carry chain, innermost used dim first
    always_comb
    begin
        used_ext = {1'b0, used};
        last_ext = '0;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            last_ext[d] = ({1'b0, cnt_cur[d]} + 17'd1) >= {1'b0, extent[d]};
        end
        cur_last = 1'b1;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            if (used[d] && !last_ext[d])
            begin
                cur_last = 1'b0;
            end
        end
        carry = '0;
        for (int d = MAX_DIMS - 1; d >= 0; d--)
        begin
            carry[d] = used_ext[d] &&
                       (!used_ext[d+1] || (carry[d+1] && last_ext[d+1]));
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        off_next = off_reg;
        pos_next = pos_reg;
        if (ctrl.rewind || (ctrl.step && cur_last))
        begin
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                cnt_next[d] = '0;
                off_next[d] = '0;
            end
            pos_next = '0;
        end
        else if (ctrl.step)
        begin
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                if (carry[d] && last_ext[d])
                begin
                    cnt_next[d] = '0;
                    off_next[d] = '0;
                end
                else if (carry[d])
                begin
                    cnt_next[d] = cnt_cur[d] + 16'd1;
                    off_next[d] = cur_offset[d] + ADDR_BITS'(stride[d]);
                end
                else
                begin
                    cnt_next[d] = cnt_cur[d];
                    off_next[d] = cur_offset[d];
                end
            end
            pos_next = cur_pos + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                cnt_reg[d] <= '0;
                off_reg[d] <= '0;
            end
            pos_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            off_reg <= off_next;
            pos_reg <= pos_next;
        end
    end

endmodule

// ===== design/strided_tensor_address_walker.sv =====
// ----------------------------------------------------------------------------
// strided_tensor_address_walker
// address generator for a strided view of up to three dimensions
// ----------------------------------------------------------------------------
// Takes one item per cycle unless stalled, through a two-stage pipeline: the
// first stage steps the walk counters or forms the index-times-stride
// products of a lookup, the second adds the base offset and the per-dimension
// terms into the source address. Kind 3 is taken and gives nothing. Walk
// items follow row-major order with the innermost used dimension fastest,
// wrap to a new pass after the last element, and every configuration write
// rewinds the walk. The user writes configuration only while the pipeline is
// empty; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module strided_tensor_address_walker #(
    parameter int MAX_DIMS  = staw_pkg::DEFAULT_MAX_DIMS,
    parameter int ADDR_BITS = staw_pkg::DEFAULT_ADDR_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_write_en,
    input  logic [staw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [staw_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         kind,
    input  logic [staw_pkg::INDEX_W-1:0]       index_outer,
    input  logic [staw_pkg::INDEX_W-1:0]       index_middle,
    input  logic [staw_pkg::INDEX_W-1:0]       index_inner,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [ADDR_BITS-1:0]               source_address,
    output logic [staw_pkg::POS_W-1:0]         dest_position,
    output logic                               final_element
);

    // configuration registers
    logic [staw_pkg::DIMS_W-1:0]   dims_reg;
    logic [staw_pkg::EXTENT_W-1:0] extent_reg [MAX_DIMS];
    logic [staw_pkg::STRIDE_W-1:0] stride_reg [MAX_DIMS];
    logic [staw_pkg::STRIDE_W-1:0] base_reg;

    // derived view shape
    logic [staw_pkg::DIMS_W-1:0]   dims_eff;
    logic [MAX_DIMS-1:0]           used;
    logic [staw_pkg::EXTENT_W-1:0] extent_eff [MAX_DIMS];

    // input side
    logic                          in_xfer;
    logic                          is_walk;
    logic                          is_lookup;
    logic [staw_pkg::INDEX_W-1:0]  idx [3];
    logic [staw_pkg::PROD_W-1:0]   prod [MAX_DIMS];
    logic [ADDR_BITS-1:0]          term [MAX_DIMS];

    // walk state interface
    staw_pkg::walk_ctrl_t          walk_ctrl;
    logic [ADDR_BITS-1:0]          walk_off [MAX_DIMS];
    logic [staw_pkg::POS_W-1:0]    walk_pos;
    logic                          walk_last;

    // stage one
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic [ADDR_BITS-1:0]          s1_term_reg [MAX_DIMS];
    logic [staw_pkg::POS_W-1:0]    s1_pos_reg;
    logic                          s1_final_reg;
    logic                          s1_ready;

    // stage two, the output register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [ADDR_BITS-1:0]          out_addr_reg;
    logic [ADDR_BITS-1:0]          out_addr_next;
    logic [staw_pkg::POS_W-1:0]    out_pos_reg;
    logic                          out_final_reg;
    logic                          s2_ready;

    // ------------------------------------------------------------------
    // configuration: each write lands in its register and rewinds the walk
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= staw_pkg::DIMS_W'(1);
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                extent_reg[d] <= staw_pkg::EXTENT_W'(1);
                stride_reg[d] <= staw_pkg::STRIDE_W'(1);
            end
            base_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                staw_pkg::CFG_DIMS_IN_USE:
                begin
                    dims_reg <= cfg_data[staw_pkg::DIMS_W-1:0];
                end
                staw_pkg::CFG_EXTENT_FIRST,
                staw_pkg::CFG_EXTENT_SECOND,
                staw_pkg::CFG_EXTENT_THIRD:
                begin
                    for (int d = 0; d < MAX_DIMS; d++)
                    begin
                        if (int'(cfg_index) == int'(staw_pkg::CFG_EXTENT_FIRST) + d)
                        begin
                            extent_reg[d] <= cfg_data[staw_pkg::EXTENT_W-1:0];
                        end
                    end
                end
                staw_pkg::CFG_STRIDE_FIRST,
                staw_pkg::CFG_STRIDE_SECOND,
                staw_pkg::CFG_STRIDE_THIRD:
                begin
                    for (int d = 0; d < MAX_DIMS; d++)
                    begin
                        if (int'(cfg_index) == int'(staw_pkg::CFG_STRIDE_FIRST) + d)
                        begin
                            stride_reg[d] <= cfg_data;
                        end
                    end
                end
                staw_pkg::CFG_BASE_OFFSET:
                begin
                    base_reg <= cfg_data;
                end
                default:
                begin
                    base_reg <= base_reg;
                end
            endcase
        end
    end

    // zero dims acts as one, too many acts as the maximum; zero extent as one
    always_comb
    begin
        if (dims_reg == '0)
        begin
            dims_eff = staw_pkg::DIMS_W'(1);
        end
        else if (int'(dims_reg) > MAX_DIMS)
        begin
            dims_eff = staw_pkg::DIMS_W'(MAX_DIMS);
        end
        else
        begin
            dims_eff = dims_reg;
        end
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            used[d]       = int'(dims_eff) > d;
            extent_eff[d] = (extent_reg[d] == '0) ? staw_pkg::EXTENT_W'(1)
                                                  : extent_reg[d];
        end
    end

    // ------------------------------------------------------------------
    // handshake: stage one takes a transfer when it is empty or moving on
    // ------------------------------------------------------------------
    assign s2_ready  = !out_valid_reg || !out_stall;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = !s1_ready;
    assign in_xfer   = in_valid && !in_stall;

    assign is_walk   = (kind == staw_pkg::KIND_WALK) || (kind == staw_pkg::KIND_RESTART);
    assign is_lookup = (kind == staw_pkg::KIND_LOOKUP);

    assign walk_ctrl.step    = in_xfer && is_walk;
    assign walk_ctrl.restart = in_xfer && (kind == staw_pkg::KIND_RESTART);
    assign walk_ctrl.rewind  = cfg_write_en;

    staw_walker #(
        .MAX_DIMS  (MAX_DIMS),
        .ADDR_BITS (ADDR_BITS)
    ) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (walk_ctrl),
        .used       (used),
        .extent     (extent_eff),
        .stride     (stride_reg),
        .cur_offset (walk_off),
        .cur_pos    (walk_pos),
        .cur_last   (walk_last)
    );

    // ------------------------------------------------------------------
    // stage one terms: walk offsets or index times stride for a lookup
    // ------------------------------------------------------------------
    assign idx[0] = index_outer;
    assign idx[1] = index_middle;
    assign idx[2] = index_inner;

    always_comb
    begin
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            prod[d] = staw_pkg::PROD_W'(idx[d]) * staw_pkg::PROD_W'(stride_reg[d]);
            if (!used[d])
            begin
                term[d] = '0;
            end
            else if (is_lookup)
            begin
                term[d] = ADDR_BITS'(prod[d]);
            end
            else
            begin
                term[d] = walk_off[d];
            end
        end
    end

    // kind 3 is taken but leaves no result
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_ready)
        begin
            s1_valid_next = in_xfer && (is_walk || is_lookup);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_term_reg  <= term;
            s1_pos_reg   <= is_lookup ? '0 : walk_pos;
            s1_final_reg <= is_lookup ? 1'b0 : walk_last;
        end
    end

    // ------------------------------------------------------------------
    // stage two: base plus the used terms, modulo the address width
    // ------------------------------------------------------------------
    always_comb
    begin
        out_addr_next = ADDR_BITS'(base_reg);
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            out_addr_next = out_addr_next + s1_term_reg[d];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s2_ready)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            out_addr_reg  <= out_addr_next;
            out_pos_reg   <= s1_pos_reg;
            out_final_reg <= s1_final_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign source_address = out_addr_reg;
    assign dest_position  = out_pos_reg;
    assign final_element  = out_final_reg;

`ifndef ASSERT_OFF
    // a full pipeline with a stalled output takes no transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && out_stall) |-> in_stall)
        else $error("transfer taken into a full pipeline");

    // stepping past the last element starts the next pass at position zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (walk_ctrl.step && walk_last) |=> (walk_pos == '0))
        else $error("walk did not wrap after the last element");

    // a configuration write rewinds the walk
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write_en |=> (walk_pos == '0))
        else $error("configuration write did not rewind the walk");
`endif

endmodule

// ===== verif/strided_tensor_address_walker_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// strided_tensor_address_walker_checker
// watches the configuration port and both channels of the address walker,
// keeps its own copy of the view and walk position, predicts every result
// transfer and compares it field by field with what the block delivers
// ----------------------------------------------------------------------------
module strided_tensor_address_walker_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [15:0] index_outer,
    input  logic [15:0] index_middle,
    input  logic [15:0] index_inner,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] source_address,
    input  logic [31:0] dest_position,
    input  logic        final_element,
    output int          mismatch_count,
    output int          elements_due
);

    typedef struct {
        logic [31:0] address;
        logic [31:0] position;
        logic        last;
    } element_t;

    element_t upcoming_elements [$];

    // view registers
    logic [1:0]  view_dims;
    logic [15:0] view_extent [3];
    logic [23:0] view_stride [3];
    logic [23:0] view_base;

    // walk position
    logic [15:0] walk_pos [3];
    logic [31:0] walk_address;
    logic [31:0] walk_count;

    function automatic int active_dims();
        int n;
        n = view_dims;
        if (n == 0) n = 1;
        if (n > staw_pkg::DEFAULT_MAX_DIMS) n = staw_pkg::DEFAULT_MAX_DIMS;
        return n;
    endfunction

    // zero extent behaves as one
    function automatic int unsigned span(int d);
        return (view_extent[d] == 16'd0) ? 1 : view_extent[d];
    endfunction

    function automatic bit on_last_element();
        int n;
        n = active_dims();
        for (int d = 0; d < n; d++)
            if (walk_pos[d] + 1 < span(d)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void rewind_walk();
        for (int d = 0; d < 3; d++) walk_pos[d] = 16'd0;
        walk_address = 32'(view_base);
        walk_count   = 32'd0;
    endfunction

    // innermost dimension steps, carries ripple outward
    function automatic void advance_walk();
        int          n;
        logic [63:0] a;
        if (on_last_element())
        begin
            rewind_walk();
            return;
        end
        n = active_dims();
        a = 64'(walk_address);
        walk_pos[n-1] = walk_pos[n-1] + 16'd1;
        a = a + 64'(view_stride[n-1]);
        for (int j = n - 1; j > 0; j--)
        begin
            if (walk_pos[j] >= span(j))
            begin
                walk_pos[j] = 16'd0;
                a = a - 64'(view_stride[j]) * 64'(span(j));
                a = a + 64'(view_stride[j-1]);
                walk_pos[j-1] = walk_pos[j-1] + 16'd1;
            end
        end
        walk_address = a[31:0];
        walk_count   = walk_count + 32'd1;
    endfunction

    function automatic element_t walk_element(bit restart);
        element_t e;
        if (restart) rewind_walk();
        e.address  = walk_address;
        e.position = walk_count;
        e.last     = on_last_element();
        advance_walk();
        return e;
    endfunction

    function automatic element_t lookup_element(logic [15:0] i0, logic [15:0] i1,
                                                logic [15:0] i2);
        element_t    e;
        logic [15:0] idx [3];
        logic [63:0] a;
        int          n;
        idx[0] = i0;
        idx[1] = i1;
        idx[2] = i2;
        n = active_dims();
        a = 64'(view_base);
        for (int d = 0; d < n; d++)
            a = a + 64'(idx[d]) * 64'(view_stride[d]);
        e.address  = a[31:0];
        e.position = 32'd0;
        e.last     = 1'b0;
        return e;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        element_t want;
        if (!rst_n)
        begin
            view_dims = 2'd1;
            for (int d = 0; d < 3; d++)
            begin
                view_extent[d] = 16'd1;
                view_stride[d] = 24'd1;
            end
            view_base = 24'd0;
            rewind_walk();
            upcoming_elements.delete();
            elements_due = 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    staw_pkg::CFG_DIMS_IN_USE:   view_dims      = cfg_data[1:0];
                    staw_pkg::CFG_EXTENT_FIRST:  view_extent[0] = cfg_data[15:0];
                    staw_pkg::CFG_EXTENT_SECOND: view_extent[1] = cfg_data[15:0];
                    staw_pkg::CFG_EXTENT_THIRD:  view_extent[2] = cfg_data[15:0];
                    staw_pkg::CFG_STRIDE_FIRST:  view_stride[0] = cfg_data;
                    staw_pkg::CFG_STRIDE_SECOND: view_stride[1] = cfg_data;
                    staw_pkg::CFG_STRIDE_THIRD:  view_stride[2] = cfg_data;
                    staw_pkg::CFG_BASE_OFFSET:   view_base      = cfg_data;
                    default: ;
                endcase
                rewind_walk();
            end

            // compare before queuing, so an empty queue is never masked
            if (out_valid && !out_stall)
            begin
                if (upcoming_elements.size() == 0)
                begin
                    $error("result transfer with nothing due: source_address %h",
                           source_address);
                    mismatch_count++;
                end
                else
                begin
                    want = upcoming_elements.pop_front();
                    if (source_address !== want.address)
                    begin
                        $error("source_address mismatch: expected %h, actual %h",
                               want.address, source_address);
                        mismatch_count++;
                    end
                    if (dest_position !== want.position)
                    begin
                        $error("dest_position mismatch: expected %h, actual %h",
                               want.position, dest_position);
                        mismatch_count++;
                    end
                    if (final_element !== want.last)
                    begin
                        $error("final_element mismatch: expected %b, actual %b",
                               want.last, final_element);
                        mismatch_count++;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                case (kind)
                    staw_pkg::KIND_WALK:
                        upcoming_elements.push_back(walk_element(1'b0));
                    staw_pkg::KIND_RESTART:
                        upcoming_elements.push_back(walk_element(1'b1));
                    staw_pkg::KIND_LOOKUP:
                        upcoming_elements.push_back(
                            lookup_element(index_outer, index_middle, index_inner));
                    default: ;
                endcase
            end

            elements_due = upcoming_elements.size();
        end
    end

endmodule

// ===== verif/strided_tensor_address_walker_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// strided_tensor_address_walker_tb
// drives walk, restart, lookup and unused-kind transfers through the address
// walker under a series of views, with random idle bursts on both sides; a
// checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module strided_tensor_address_walker_tb;

    localparam int         LATENCY       = 2;
    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         RANDOM_PHASES = 10;
    localparam int         PHASE_ITEMS   = 55;
    localparam int         CALM_PHASES   = 2;      // last phases run without idling
    localparam logic [1:0] KIND_UNUSED   = 2'd3;   // taken by the block, gives nothing

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [2:0]  cfg_index    = 3'd0;
    logic [23:0] cfg_data     = 24'd0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [1:0]  kind         = 2'd0;
    logic [15:0] index_outer  = 16'd0;
    logic [15:0] index_middle = 16'd0;
    logic [15:0] index_inner  = 16'd0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [31:0] source_address;
    logic [31:0] dest_position;
    logic        final_element;

    int          mismatch_count;
    int          elements_due;
    bit          idle_enable = 1'b0;
    int          stall_left  = 0;
    int          cycle_count = 0;
    logic [15:0] shadow_extent [3] = '{16'd1, 16'd1, 16'd1};

    strided_tensor_address_walker dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .index_outer    (index_outer),
        .index_middle   (index_middle),
        .index_inner    (index_inner),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .source_address (source_address),
        .dest_position  (dest_position),
        .final_element  (final_element)
    );

    strided_tensor_address_walker_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .index_outer    (index_outer),
        .index_middle   (index_middle),
        .index_inner    (index_inner),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .source_address (source_address),
        .dest_position  (dest_position),
        .final_element  (final_element),
        .mismatch_count (mismatch_count),
        .elements_due   (elements_due)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("strided_tensor_address_walker test failed");
            $finish;
        end
    end

    // receiver back-pressure: random stall bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (idle_enable && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 13) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // one transfer on the input channel, with an optional idle burst ahead of it;
    // valid stays high on return so back-to-back items need no extra edge
    task automatic send_item(logic [1:0] k, logic [15:0] i0, logic [15:0] i1,
                             logic [15:0] i2);
        int gap;
        if (idle_enable && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 13);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        kind         <= k;
        index_outer  <= i0;
        index_middle <= i1;
        index_inner  <= i2;
        // transfer happens at the first rising edge without stall
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // drop valid and wait until every result has come out, and then long enough
    // that an unused-kind item still in flight has drained too
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (elements_due != 0) @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    task automatic write_reg(staw_pkg::cfg_reg_t r, logic [23:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= r;
        cfg_data     <= value;
    endtask

    // full view setup, every register written; only called when idle
    task automatic write_view(logic [1:0] d, logic [15:0] e0, logic [15:0] e1,
                              logic [15:0] e2, logic [23:0] s0, logic [23:0] s1,
                              logic [23:0] s2, logic [23:0] b);
        write_reg(staw_pkg::CFG_DIMS_IN_USE, 24'(d));
        write_reg(staw_pkg::CFG_EXTENT_FIRST, 24'(e0));
        write_reg(staw_pkg::CFG_EXTENT_SECOND, 24'(e1));
        write_reg(staw_pkg::CFG_EXTENT_THIRD, 24'(e2));
        write_reg(staw_pkg::CFG_STRIDE_FIRST, s0);
        write_reg(staw_pkg::CFG_STRIDE_SECOND, s1);
        write_reg(staw_pkg::CFG_STRIDE_THIRD, s2);
        write_reg(staw_pkg::CFG_BASE_OFFSET, b);
        @(negedge clk);
        cfg_write_en <= 1'b0;
        shadow_extent[0] = e0;
        shadow_extent[1] = e1;
        shadow_extent[2] = e2;
    endtask

    function automatic logic [15:0] pick_extent();
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 5));   // zero included, acts as one
    endfunction

    function automatic logic [23:0] pick_stride();
        case ($urandom_range(0, 5))
            0:       return 24'd0;
            1:       return 24'hFFFFFF;
            2:       return 24'($urandom_range(1, 16));
            default: return 24'($urandom);
        endcase
    endfunction

    // lookup index: mostly inside the extent, sometimes anywhere or at the ends
    function automatic logic [15:0] pick_index(int d);
        int unsigned lim;
        lim = (shadow_extent[d] == 16'd0) ? 1 : shadow_extent[d];
        case ($urandom_range(0, 4))
            0:       return 16'($urandom);
            1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
            default: return 16'($urandom_range(0, lim - 1));
        endcase
    endfunction

    // mostly walks so passes run through their carries and wrap
    task automatic random_item();
        int          r;
        logic [1:0]  k;
        r = $urandom_range(0, 99);
        if (r < 58)      k = staw_pkg::KIND_WALK;
        else if (r < 65) k = staw_pkg::KIND_RESTART;
        else if (r < 92) k = staw_pkg::KIND_LOOKUP;
        else             k = KIND_UNUSED;
        if (k == staw_pkg::KIND_LOOKUP)
            send_item(k, pick_index(0), pick_index(1), pick_index(2));
        else
            send_item(k, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        // reset held low, then released once
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset view: single element, every walk is the last
        send_item(staw_pkg::KIND_WALK, 16'h0000, 16'h0000, 16'h0000);
        send_item(staw_pkg::KIND_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(KIND_UNUSED, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_item(staw_pkg::KIND_WALK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        settle();

        // 2x3x2 view: restart then a full pass and the wrap into the next
        write_view(2'd3, 16'd2, 16'd3, 16'd2, 24'd100, 24'd10, 24'd1, 24'h001000);
        send_item(staw_pkg::KIND_RESTART, 16'd0, 16'd0, 16'd0);
        repeat (12)
            send_item(staw_pkg::KIND_WALK, 16'($urandom), 16'($urandom), 16'($urandom));
        send_item(staw_pkg::KIND_LOOKUP, 16'd1, 16'd2, 16'd1);
        settle();

        // largest extents, strides and base: lookup sum wraps past 2^32
        write_view(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF,
                   24'hFFFFFF, 24'hFFFFFF);
        send_item(staw_pkg::KIND_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(staw_pkg::KIND_WALK, 16'd0, 16'd0, 16'd0);
        send_item(staw_pkg::KIND_WALK, 16'd0, 16'd0, 16'd0);
        settle();

        // zero dims and zero extents behave as one
        write_view(2'd0, 16'd0, 16'd0, 16'd0, 24'd0, 24'd0, 24'd0, 24'd0);
        send_item(staw_pkg::KIND_WALK, 16'd0, 16'd0, 16'd0);
        send_item(staw_pkg::KIND_LOOKUP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(staw_pkg::KIND_RESTART, 16'd0, 16'd0, 16'd0);
        settle();

        // random phases, each under a fresh view
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            idle_enable = (p < RANDOM_PHASES - CALM_PHASES) && ($urandom_range(0, 3) != 0);
            if (p == 1)
                write_view(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF,
                           24'hFFFFFF, 24'hFFFFFF);
            else if (p == 2)
                write_view(2'd0, 16'd0, 16'd0, 16'd0, 24'd0, 24'd0, 24'd0, 24'd0);
            else
                write_view(2'($urandom_range(0, 3)), pick_extent(), pick_extent(),
                           pick_extent(), pick_stride(), pick_stride(), pick_stride(),
                           24'($urandom));
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // sender holds off mid-phase until all results are out
                if (p == 4 && i == PHASE_ITEMS / 2) settle();
                random_item();
            end
            settle();
        end

        if (mismatch_count == 0 && elements_due == 0)
            $display("strided_tensor_address_walker test passed");
        else
            $display("strided_tensor_address_walker test failed");
        $finish;
    end

endmodule
